// ===== rtl/fixed_block_free_list_allocator_macros.svh =====
// Assertion macros for the fixed block free list allocator checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FBFL_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define FBFL_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fbfl_pkg.sv =====
// Shared types and constants of the fixed block free list allocator.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package fbfl_pkg;

	localparam int NUM_BLOCKS_DEF  = 32;
	localparam int BLOCK_BYTES_DEF = 128;

	localparam logic [31:0] POOL_TOP_RESET = 32'h1000_8000;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear_we;
		logic accept;
		logic div_en;
		logic chk_en;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_done;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/fixed_block_free_list_allocator.sv =====
// Block request: goes from idle to the done state, its result set by
// the registered read of the link memory at the head. One request at a time.
// Block release: goes through the divide and check states, its result set by
// the address check (subtract, reciprocal multiply, multiply back, compare).
// After reset the link memory is initialized one entry a cycle, all NUM_BLOCKS
// entries; requests stall meanwhile, pool_top writes are taken as ever.
`default_nettype none

module fixed_block_free_list_allocator #(
	parameter int NUM_BLOCKS  = fbfl_pkg::NUM_BLOCKS_DEF,
	parameter int BLOCK_BYTES = fbfl_pkg::BLOCK_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [31:0] addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] block_addr,
	output logic [5:0]  free_blocks,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	fbfl_pkg::dp_cmd_t  ctl;
	fbfl_pkg::dp_stat_t stat;

	fbfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl),
		.stat      (stat)
	);

	fbfl_datapath #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.addr        (addr),
		.status      (status),
		.block_addr  (block_addr),
		.free_blocks (free_blocks)
	);

endmodule

`default_nettype wire

// ===== rtl/fbfl_ctrl.sv =====
// Controller of the free list allocator: sequences link clearing, request
// steps and the output register handshake. Depends on fbfl_pkg.
`default_nettype none

module fbfl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	output logic               out_valid,
	input  logic               out_stall,
	output fbfl_pkg::dp_cmd_t  ctl,
	input  fbfl_pkg::dp_stat_t stat
);

	fbfl_pkg::state_t state_q;
	fbfl_pkg::state_t state_nxt;
	logic             out_valid_q;
	logic             commit;

	assign commit    = (state_q == fbfl_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fbfl_pkg::ST_CLEAR: begin
				if (stat.clear_done) begin
					state_nxt = fbfl_pkg::ST_IDLE;
				end
			end
			fbfl_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (cmd == fbfl_pkg::CMD_FREE) ? fbfl_pkg::ST_DIV
						: fbfl_pkg::ST_DONE;
				end
			end
			fbfl_pkg::ST_DIV: begin
				state_nxt = fbfl_pkg::ST_CHK;
			end
			fbfl_pkg::ST_CHK: begin
				state_nxt = fbfl_pkg::ST_DONE;
			end
			fbfl_pkg::ST_DONE: begin
				if (commit) begin
					state_nxt = fbfl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = fbfl_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		ctl          = '0;
		in_stall     = 1'b1;
		unique case (state_q)
			fbfl_pkg::ST_CLEAR: begin
				ctl.clear_we = 1'b1;
			end
			fbfl_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				ctl.accept = in_valid;
			end
			fbfl_pkg::ST_DIV: begin
				ctl.div_en = 1'b1;
			end
			fbfl_pkg::ST_CHK: begin
				ctl.chk_en = 1'b1;
			end
			fbfl_pkg::ST_DONE: begin
				ctl.commit = commit;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fbfl_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// a new result wins over the one being taken in the same cycle
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fbfl_datapath.sv =====
// Datapath of the free list allocator: link memory, head and count, address
// check by reciprocal multiply, and the result register. Depends on fbfl_pkg.
`default_nettype none

module fbfl_datapath #(
	parameter int NUM_BLOCKS  = fbfl_pkg::NUM_BLOCKS_DEF,
	parameter int BLOCK_BYTES = fbfl_pkg::BLOCK_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fbfl_pkg::dp_cmd_t  ctl,
	output fbfl_pkg::dp_stat_t stat,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	input  logic               cmd,
	input  logic [31:0]        addr,
	output logic [1:0]         status,
	output logic [31:0]        block_addr,
	output logic [5:0]         free_blocks
);

	localparam int IDX_W      = $clog2(NUM_BLOCKS + 1);
	localparam int ADDR_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int POOL_BYTES = NUM_BLOCKS * BLOCK_BYTES;
	localparam int DIFF_W     = $clog2(POOL_BYTES + 1);
	localparam int SHIFT      = DIFF_W + $clog2(BLOCK_BYTES);
	localparam int PROD_W     = SHIFT + IDX_W;
	localparam longint unsigned RECIP_L =
		((64'd1 << SHIFT) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
	localparam logic [PROD_W-1:0] RECIP    = PROD_W'(RECIP_L);
	localparam logic [IDX_W-1:0]  NULL_IDX = IDX_W'(NUM_BLOCKS);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
	localparam logic [31:0]       POOL_SZ  = 32'(POOL_BYTES);

	logic [IDX_W-1:0]  link_mem [NUM_BLOCKS];

	logic [31:0]       top_q;
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  count_q;
	logic [IDX_W-1:0]  clr_q;
	logic [IDX_W-1:0]  rd_q;
	logic [31:0]       off_q;
	logic              cmd_q;
	logic [31:0]       diff_s1;
	logic [IDX_W-1:0]  q_s2;
	logic              range_s2;
	logic              ok_s3;
	logic [1:0]        status_q;
	logic [31:0]       block_addr_q;
	logic [5:0]        free_q;

	logic [PROD_W-1:0] prod;
	logic [31:0]       qb;
	logic [IDX_W-1:0]  rel_idx;
	logic              empty;
	logic              push_we;
	logic [IDX_W-1:0]  head_nxt;
	logic [IDX_W-1:0]  count_nxt;
	logic [1:0]        status_nxt;
	logic [31:0]       baddr_nxt;
	logic [IDX_W+5:0]  free_ext;

	assign stat.clear_done = (clr_q == LAST_IDX);

	always_comb begin
		prod     = PROD_W'(diff_s1[DIFF_W-1:0]) * RECIP;
		qb       = 32'(q_s2) * 32'(BLOCK_BYTES);
		rel_idx  = q_s2 - IDX_W'(1);
		empty    = (head_q == NULL_IDX);
		push_we  = ctl.commit && (cmd_q == fbfl_pkg::CMD_FREE) && ok_s3;
		free_ext = {6'd0, count_nxt};
	end

	always_comb begin
		head_nxt   = head_q;
		count_nxt  = count_q;
		status_nxt = fbfl_pkg::STATUS_OK;
		baddr_nxt  = '0;
		if (cmd_q == fbfl_pkg::CMD_ALLOC) begin
			if (empty) begin
				status_nxt = fbfl_pkg::STATUS_EMPTY;
			end else begin
				baddr_nxt = top_q - off_q;
				head_nxt  = rd_q;
				if (count_q != '0) begin
					count_nxt = count_q - IDX_W'(1);
				end
			end
		end else if (!ok_s3) begin
			status_nxt = fbfl_pkg::STATUS_BAD_ADDR;
		end else begin
			head_nxt = rel_idx;
			if (count_q != NULL_IDX) begin
				count_nxt = count_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= fbfl_pkg::POOL_TOP_RESET;
			head_q  <= '0;
			count_q <= NULL_IDX;
			clr_q   <= '0;
		end else begin
			if (cfg_we) begin
				top_q <= cfg_wdata;
			end
			if (ctl.clear_we) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (ctl.commit) begin
				head_q  <= head_nxt;
				count_q <= count_nxt;
			end
		end
	end

	// head link and block offset follow the head every cycle
	always_ff @(posedge clk) begin
		rd_q  <= link_mem[head_q[ADDR_W-1:0]];
		off_q <= 32'(head_q + IDX_W'(1)) * 32'(BLOCK_BYTES);
		if (ctl.accept) begin
			cmd_q   <= cmd;
			diff_s1 <= top_q - addr;
		end
		if (ctl.div_en) begin
			q_s2     <= prod[SHIFT +: IDX_W];
			range_s2 <= (diff_s1 != '0) && (diff_s1 <= POOL_SZ);
		end
		if (ctl.chk_en) begin
			ok_s3 <= range_s2 && (qb == diff_s1);
		end
		if (ctl.commit) begin
			status_q     <= status_nxt;
			block_addr_q <= baddr_nxt;
			free_q       <= free_ext[5:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear_we) begin
			link_mem[clr_q[ADDR_W-1:0]] <= clr_q + IDX_W'(1);
		end else if (push_we) begin
			link_mem[rel_idx[ADDR_W-1:0]] <= head_q;
		end
	end

	assign status      = status_q;
	assign block_addr  = block_addr_q;
	assign free_blocks = free_q;

endmodule

`default_nettype wire

// ===== rtl/fbfl_checker.sv =====
// Port-level checker for the free list allocator, bound to the top level.
// Depends on fbfl_pkg and fixed_block_free_list_allocator_macros.svh.
`default_nettype none
`include "fixed_block_free_list_allocator_macros.svh"

module fbfl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] block_addr
);

	// hold a stalled result
	`FBFL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(block_addr), "stalled result changed")

	`FBFL_ASSERT_IMP(a_status_legal, out_valid, status == fbfl_pkg::STATUS_OK || status == fbfl_pkg::STATUS_EMPTY || status == fbfl_pkg::STATUS_BAD_ADDR, "illegal status code")

	`FBFL_ASSERT_IMP(a_fail_no_addr, out_valid && status != fbfl_pkg::STATUS_OK, block_addr == '0, "failed request carries an address")

	// one request in flight at a time
	`FBFL_ASSERT_NXT(a_one_in_flight, in_valid && !in_stall, in_stall, "request accepted back to back")

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.block_addr (block_addr)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for fixed_block_free_list_allocator: a scripted opening,
// constrained-by-hand random phases over several pool_top values, and a double-free tail.
// Depends on fbfl_pkg (rtl/fbfl_pkg.sv) and the allocator RTL only.
module tb;
	import fbfl_pkg::*;

	localparam int NUM = NUM_BLOCKS_DEF;
	localparam int BLOCK = BLOCK_BYTES_DEF;
	localparam logic [31:0] BLOCK_SZ = 32'(BLOCK_BYTES_DEF);
	localparam logic [5:0] NULL_LINK = 6'(NUM_BLOCKS_DEF);
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_ITEMS = 55;
	localparam logic CHK_PREDICTED = 1'b0;
	localparam logic CHK_TYPED = 1'b1;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] block_addr;
		logic [5:0]  free_blocks;
	} pool_result_t;

	typedef struct packed {
		logic         op;
		logic [31:0]  operand;
		logic         check;
		pool_result_t outcome;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        cmd = 1'b0;
	logic [31:0] addr = 32'h0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] block_addr;
	logic [5:0]  free_blocks;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = 32'h0;

	fixed_block_free_list_allocator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.addr        (addr),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.block_addr  (block_addr),
		.free_blocks (free_blocks),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the pool
	logic [31:0] live_top;
	logic [5:0]  link_mem [NUM];
	logic [5:0]  pool_head;
	logic [5:0]  pool_free;
	logic [5:0]  held_blocks [$];

	pool_result_t pending_results [$];
	pool_result_t want, got;

	bit jitter_on = 1'b1;
	int errors = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int n_req = 0, n_grant = 0, n_empty = 0, n_rel = 0, n_bad = 0, n_checked = 0;
	int n_tops = 0;

	// Opening script at the reset pool_top 0x1000_8000
	script_row_t opening_rows [13] = '{
		'{CMD_ALLOC, 32'h0000_0000, CHK_TYPED, '{STATUS_OK, 32'h1000_7F80, 6'd31}},
		'{CMD_ALLOC, 32'hFFFF_FFFF, CHK_TYPED, '{STATUS_OK, 32'h1000_7F00, 6'd30}},
		'{CMD_FREE,  32'h1000_7F80, CHK_TYPED, '{STATUS_OK, 32'h0, 6'd31}},
		'{CMD_FREE,  32'h1000_8000, CHK_TYPED, '{STATUS_BAD_ADDR, 32'h0, 6'd31}},
		'{CMD_FREE,  32'h1000_7F81, CHK_TYPED, '{STATUS_BAD_ADDR, 32'h0, 6'd31}},
		'{CMD_FREE,  32'h1000_6F80, CHK_TYPED, '{STATUS_BAD_ADDR, 32'h0, 6'd31}},
		'{CMD_FREE,  32'h1000_8080, CHK_TYPED, '{STATUS_BAD_ADDR, 32'h0, 6'd31}},
		'{CMD_FREE,  32'h0000_0000, CHK_TYPED, '{STATUS_BAD_ADDR, 32'h0, 6'd31}},
		'{CMD_FREE,  32'hFFFF_FFFF, CHK_TYPED, '{STATUS_BAD_ADDR, 32'h0, 6'd31}},
		'{CMD_ALLOC, 32'h5555_AAAA, CHK_TYPED, '{STATUS_OK, 32'h1000_7F80, 6'd30}},
		'{CMD_ALLOC, 32'hAAAA_5555, CHK_PREDICTED, '0},
		'{CMD_FREE,  32'h1000_7F00, CHK_PREDICTED, '0},
		'{CMD_FREE,  32'h1000_7E80, CHK_PREDICTED, '0}
	};

	// Closing script: full pool, block 0 released twice so it links to itself
	script_row_t closing_rows [4] = '{
		'{CMD_FREE,  32'h1000_7F80, CHK_TYPED, '{STATUS_OK, 32'h0, 6'd32}},
		'{CMD_FREE,  32'h1000_7F80, CHK_TYPED, '{STATUS_OK, 32'h0, 6'd32}},
		'{CMD_ALLOC, 32'h0000_0000, CHK_TYPED, '{STATUS_OK, 32'h1000_7F80, 6'd31}},
		'{CMD_ALLOC, 32'hFFFF_FFFF, CHK_TYPED, '{STATUS_OK, 32'h1000_7F80, 6'd30}}
	};

	function automatic logic [31:0] block_address(input logic [5:0] idx);
		return live_top - (32'(idx) + 32'd1) * BLOCK_SZ;
	endfunction

	function automatic logic decode_release(input logic [31:0] a, output logic [5:0] idx);
		logic [31:0] diff;
		logic [31:0] q;
		diff = live_top - a;
		q = diff / BLOCK_SZ;
		idx = q[5:0] - 6'd1;
		return diff != 32'd0 && diff % BLOCK_SZ == 32'd0 && q >= 32'd1 && q <= 32'(NUM);
	endfunction

	function automatic pool_result_t pool_apply(input logic c, input logic [31:0] a,
			output logic [5:0] idx);
		pool_result_t r;
		r = '0;
		idx = '0;
		if (c == CMD_ALLOC) begin
			if (pool_head >= NULL_LINK) begin
				r.status = STATUS_EMPTY;
			end else begin
				idx = pool_head;
				r.block_addr = block_address(pool_head);
				pool_head = link_mem[pool_head];
				if (pool_free != 6'd0)
					pool_free = pool_free - 6'd1;
			end
		end else if (!decode_release(a, idx)) begin
			r.status = STATUS_BAD_ADDR;
		end else begin
			link_mem[idx] = pool_head;
			pool_head = idx;
			if (pool_free < 6'(NUM))
				pool_free = pool_free + 6'd1;
		end
		r.free_blocks = pool_free;
		return r;
	endfunction

	// Release address that is never the start of a pool block
	function automatic logic [31:0] stray_address();
		logic [31:0] a;
		logic [5:0] idx;
		do begin
			case ($urandom_range(3))
				0: a = $urandom;
				1: a = live_top - $urandom_range(34) * BLOCK_SZ + $urandom_range(1, BLOCK - 1);
				2: a = live_top - $urandom_range(33, 34) * BLOCK_SZ;
				default: a = live_top + $urandom_range(1) * BLOCK_SZ;
			endcase
		end while (decode_release(a, idx));
		return a;
	endfunction

	task automatic issue(input logic c, input logic [31:0] a, input logic check,
			input pool_result_t typed);
		pool_result_t r;
		logic [5:0] idx;
		while (jitter_on && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		addr <= a;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = pool_apply(c, a, idx);
		items_sent++;
		if (c == CMD_ALLOC) begin
			n_req++;
			if (r.status == STATUS_OK) begin
				n_grant++;
				held_blocks.push_back(idx);
			end else begin
				n_empty++;
			end
		end else begin
			n_rel++;
			if (r.status == STATUS_OK) begin
				for (int k = 0; k < held_blocks.size(); k++) begin
					if (held_blocks[k] == idx) begin
						held_blocks.delete(k);
						break;
					end
				end
			end else begin
				n_bad++;
			end
		end
		pending_results.push_back(check == CHK_TYPED ? typed : r);
	endtask

	task automatic issue_predicted(input logic c, input logic [31:0] a);
		issue(c, a, CHK_PREDICTED, '0);
	endtask

	task automatic release_held(input int k);
		logic [5:0] idx;
		idx = held_blocks[k];
		issue_predicted(CMD_FREE, block_address(idx));
	endtask

	task automatic refill_pool();
		while (held_blocks.size() != 0)
			release_held($urandom_range(held_blocks.size() - 1));
	endtask

	// Write only with nothing in flight
	task automatic program_top(input logic [31:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		live_top = v;
		n_tops++;
	endtask

	task automatic run_phase(input int budget);
		int start;
		int pick;
		start = items_sent;
		while (items_sent - start < budget) begin
			pick = $urandom_range(9);
			if (pick < 2) begin
				// drain to empty, then knock on the empty pool
				while (pool_head != NULL_LINK)
					issue_predicted(CMD_ALLOC, $urandom);
				repeat ($urandom_range(1, 3))
					issue_predicted(CMD_ALLOC, $urandom);
			end else if (pick == 2) begin
				refill_pool();
			end else begin
				repeat ($urandom_range(8, 16)) begin
					pick = $urandom_range(99);
					if (pick >= 90)
						issue_predicted(CMD_FREE, stray_address());
					else if (pick >= 55 && held_blocks.size() != 0)
						release_held($urandom_range(held_blocks.size() - 1));
					else
						issue_predicted(CMD_ALLOC, $urandom);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		out_stall <= jitter_on && ($urandom_range(99) < 31);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got = {status, block_addr, free_blocks};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: status %0d block_addr %h free_blocks %0d",
					$time, got.status, got.block_addr, got.free_blocks);
				errors++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, want.status, got.status);
					errors++;
				end
				if (got.block_addr !== want.block_addr) begin
					$display("%0t: block_addr expected %h, got %h",
						$time, want.block_addr, got.block_addr);
					errors++;
				end
				if (got.free_blocks !== want.free_blocks) begin
					$display("%0t: free_blocks expected %0d, got %0d",
						$time, want.free_blocks, got.free_blocks);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d results outstanding",
				$time, pending_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		logic [31:0] phase_tops [6];
		phase_tops = '{32'h0000_0800, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0,
			32'h8000_0040, 32'h0};
		phase_tops[3] = $urandom;
		phase_tops[5] = $urandom & ~(BLOCK_SZ - 32'd1);
		live_top = POOL_TOP_RESET;
		for (int i = 0; i < NUM; i++)
			link_mem[i] = 6'(i + 1);
		pool_head = 6'd0;
		pool_free = 6'(NUM);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (opening_rows[r])
			issue(opening_rows[r].op, opening_rows[r].operand, opening_rows[r].check,
				opening_rows[r].outcome);

		// one phase runs with both sides at full rate
		foreach (phase_tops[p]) begin
			program_top(phase_tops[p]);
			jitter_on = (p != 2);
			run_phase(PHASE_ITEMS);
		end

		refill_pool();
		jitter_on = 1'b1;
		program_top(POOL_TOP_RESET);
		foreach (closing_rows[r])
			issue(closing_rows[r].op, closing_rows[r].operand, closing_rows[r].check,
				closing_rows[r].outcome);
		// walk the self-linked block until the count bottoms out
		repeat (34)
			issue_predicted(CMD_ALLOC, $urandom);
		issue_predicted(CMD_FREE, block_address(6'd5));
		issue_predicted(CMD_ALLOC, $urandom);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("run covered %0d requests (%0d granted, %0d on an empty pool) and %0d releases",
			n_req, n_grant, n_empty, n_rel);
		$display("%0d releases rejected, %0d pool_top writes, %0d results compared",
			n_bad, n_tops, n_checked);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
